### rtl/core/prs_pkg.sv
package prs_pkg;

    localparam int MAX_NUMBER_DEF = 1024;
    localparam int NUM_W          = 10;
    localparam int ADDR_W         = 3;
    localparam int DATA_W         = 32;
    localparam int QUEUE_DEPTH    = 2;
    localparam int BASE_FIRST     = 2;

    localparam logic [NUM_W-1:0] LIMIT_RESET = 10'd1023;

    localparam logic CMD_BUILD = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [ADDR_W-3:0] REG_UPPER_LIMIT = 1'b0;

    typedef struct packed {
        logic             is_build;
        logic [NUM_W-1:0] number;
    } t_job;

    typedef struct packed {
        logic [NUM_W-1:0] limit;
        logic             limit_wr;
    } t_cfg;

    typedef struct packed {
        logic [NUM_W-1:0] number_echo;
        logic             is_prime;
        logic             in_range;
        logic             ready_res;
    } t_rsp;

endpackage

### rtl/core/prs_if.sv
interface prs_req_if;
    import prs_pkg::*;

    logic             valid;
    logic             ready;
    logic             cmd;
    logic [NUM_W-1:0] query_number;

    modport source (output valid, output cmd, output query_number, input ready);
    modport sink (input valid, input cmd, input query_number, output ready);
endinterface

interface prs_rsp_if;
    import prs_pkg::*;

    logic             valid;
    logic             ready;
    logic [NUM_W-1:0] number_echo;
    logic             is_prime;
    logic             in_range;
    logic             ready_res;

    modport source (output valid, output number_echo, output is_prime, output in_range,
                    output ready_res, input ready);
    modport sink (input valid, input number_echo, input is_prime, input in_range,
                  input ready_res, output ready);
endinterface

### rtl/core/prs_regs.sv
module prs_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [prs_pkg::ADDR_W-1:0]    paddr,
    input  logic [prs_pkg::DATA_W-1:0]    pwdata,
    output logic [prs_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output prs_pkg::t_cfg                 o_cfg
);
    import prs_pkg::*;

    logic [NUM_W-1:0] r_limit;
    logic [NUM_W-1:0] n_limit;
    logic             wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_UPPER_LIMIT);

    always_comb begin
        n_limit = r_limit;
        if (wr_hit) begin
            n_limit = pwdata[NUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else begin
            r_limit <= n_limit;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[ADDR_W-1:2] == REG_UPPER_LIMIT) begin
            prdata = DATA_W'(r_limit);
        end
    end

    assign o_cfg.limit    = r_limit;
    assign o_cfg.limit_wr = wr_hit;

endmodule

### rtl/core/prs_front.sv
module prs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    prs_req_if.sink       i_req,
    output logic          o_job_valid,
    input  logic          i_job_ready,
    output prs_pkg::t_job o_job
);
    import prs_pkg::*;

    localparam int PW   = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    t_job              r_q [QUEUE_DEPTH];
    logic [PW-1:0]     r_wptr;
    logic [PW-1:0]     r_rptr;
    logic [CNTW-1:0]   r_count;
    logic [PW-1:0]     n_wptr;
    logic [PW-1:0]     n_rptr;
    logic [CNTW-1:0]   n_count;
    t_job              job_in;
    logic              push;
    logic              pop;

    assign job_in.is_build = (i_req.cmd == CMD_BUILD);
    assign job_in.number   = i_req.query_number;

    assign i_req.ready = (r_count != CNTW'(QUEUE_DEPTH));
    assign o_job_valid = (r_count != '0);
    assign o_job       = r_q[r_rptr];

    assign push = i_req.valid && i_req.ready;
    assign pop  = o_job_valid && i_job_ready;

    always_comb begin
        n_wptr  = push ? r_wptr + PW'(1) : r_wptr;
        n_rptr  = pop ? r_rptr + PW'(1) : r_rptr;
        n_count = r_count + CNTW'(push) - CNTW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= job_in;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wptr == r_rptr))
        else $error("empty queue with unequal pointers");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CNTW'(QUEUE_DEPTH)) |-> !i_req.ready)
        else $error("full queue still accepting");

endmodule

### rtl/core/prs_back.sv
module prs_back #(
    parameter int MAX_NUMBER = prs_pkg::MAX_NUMBER_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  prs_pkg::t_cfg i_cfg,
    input  logic          i_job_valid,
    output logic          o_job_ready,
    input  prs_pkg::t_job i_job,
    prs_rsp_if.source     o_rsp
);
    import prs_pkg::*;

    localparam int AW      = $clog2(MAX_NUMBER);
    localparam int CW      = NUM_W + 1;
    localparam int SQW     = 2 * NUM_W;
    localparam int LIM_CAP = (MAX_NUMBER - 1 > 1023) ? 1023 : MAX_NUMBER - 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_TEST  = 3'd2;
    localparam logic [2:0] ST_MARK  = 3'd3;
    localparam logic [2:0] ST_SRD   = 3'd4;
    localparam logic [2:0] ST_SCHK  = 3'd5;
    localparam logic [2:0] ST_QRD   = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic             r_map [MAX_NUMBER];
    logic             r_rdata;

    logic [2:0]       r_state,     n_state;
    logic [CW-1:0]    r_addr,      n_addr;
    logic [NUM_W-1:0] r_base,      n_base;
    logic [NUM_W-1:0] r_lim,       n_lim;
    logic [NUM_W-1:0] r_num,       n_num;
    logic             r_is_build,  n_is_build;
    logic             r_built,     n_built;
    logic             r_out_valid, n_out_valid;
    t_rsp             r_out,       n_out;

    logic             mem_we;
    logic             mem_wdata;
    logic [AW-1:0]    mem_waddr;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [NUM_W-1:0] eff_lim;
    logic [CW-1:0]    lim_ext;
    logic [SQW-1:0]   base_sq;
    logic             q_inr;

    assign eff_lim = (i_cfg.limit > NUM_W'(LIM_CAP)) ? NUM_W'(LIM_CAP) : i_cfg.limit;
    assign lim_ext = CW'(r_lim);
    assign base_sq = SQW'(r_base) * SQW'(r_base);
    assign q_inr   = (r_num >= NUM_W'(BASE_FIRST)) && (r_num <= r_lim);

    assign o_job_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_base      = r_base;
        n_lim       = r_lim;
        n_num       = r_num;
        n_is_build  = r_is_build;
        n_built     = r_built;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_wdata   = 1'b0;
        mem_waddr   = AW'(r_addr);
        mem_re      = 1'b0;
        mem_raddr   = AW'(r_addr);

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cfg.limit_wr) begin
            n_built = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_lim      = eff_lim;
                    n_is_build = i_job.is_build;
                    n_num      = i_job.number;
                    if (i_job.is_build) begin
                        n_addr  = CW'(BASE_FIRST);
                        n_state = ST_CLEAR;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(i_job.number);
                        n_state   = ST_QRD;
                    end
                end
            end
            ST_CLEAR: begin
                if (r_addr > lim_ext) begin
                    n_base  = NUM_W'(BASE_FIRST);
                    n_state = ST_TEST;
                end else begin
                    mem_we    = 1'b1;
                    mem_wdata = 1'b0;
                    n_addr    = r_addr + CW'(1);
                end
            end
            ST_TEST: begin
                if (base_sq <= SQW'(r_lim)) begin
                    n_addr  = CW'(r_base) + CW'(r_base);
                    n_state = ST_MARK;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_MARK: begin
                if (r_addr > lim_ext) begin
                    n_addr  = CW'(r_base) + CW'(1);
                    n_state = ST_SRD;
                end else begin
                    mem_we    = 1'b1;
                    mem_wdata = 1'b1;
                    n_addr    = r_addr + CW'(r_base);
                end
            end
            ST_SRD: begin
                if (r_addr > lim_ext) begin
                    n_state = ST_DONE;
                end else begin
                    mem_re  = 1'b1;
                    n_state = ST_SCHK;
                end
            end
            ST_SCHK: begin
                if (!r_rdata) begin
                    n_base  = r_addr[NUM_W-1:0];
                    n_state = ST_TEST;
                end else begin
                    n_addr  = r_addr + CW'(1);
                    n_state = ST_SRD;
                end
            end
            ST_QRD: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    if (r_is_build) begin
                        n_built           = 1'b1;
                        n_out.number_echo = i_cfg.limit;
                        n_out.is_prime    = 1'b0;
                        n_out.in_range    = 1'b0;
                        n_out.ready_res   = 1'b1;
                    end else begin
                        n_out.number_echo = r_num;
                        n_out.is_prime    = q_inr && r_built && !r_rdata;
                        n_out.in_range    = q_inr;
                        n_out.ready_res   = r_built;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_base      <= NUM_W'(BASE_FIRST);
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_built     <= n_built;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_lim      <= n_lim;
        r_num      <= n_num;
        r_is_build <= n_is_build;
        r_out      <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_map[mem_raddr];
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.number_echo = r_out.number_echo;
    assign o_rsp.is_prime    = r_out.is_prime;
    assign o_rsp.in_range    = r_out.in_range;
    assign o_rsp.ready_res   = r_out.ready_res;

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> ((r_state == ST_CLEAR) || (r_state == ST_MARK)))
        else $error("map write outside clear or mark");

    a_write_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_addr <= lim_ext))
        else $error("map write beyond limit");

    a_base_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base >= NUM_W'(BASE_FIRST))
        else $error("sieve base below two");

    a_rsp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result raised outside done");

endmodule

### rtl/core/prime_sieve_engine_top.sv
// Query: the map read is issued on acceptance; in ST_DONE the result is
// registered once the output is free; a new query waits for idle again.
// Build: clear 2..limit, then per base a test, a mark pass over its
// multiples and a candidate search; the map takes one access a cycle.
// Reset (sync, active low) clears control state, sets upper_limit to 1023;
// the map itself is not cleared at reset: each build clears 2..limit first.
module prime_sieve_engine_top #(
    parameter int MAX_NUMBER = prs_pkg::MAX_NUMBER_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    prs_req_if.sink                    i_req,
    prs_rsp_if.source                  o_rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [prs_pkg::ADDR_W-1:0] paddr,
    input  logic [prs_pkg::DATA_W-1:0] pwdata,
    output logic [prs_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import prs_pkg::*;

    t_cfg cfg;
    t_job job;
    logic job_valid;
    logic job_ready;

    prs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    prs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job)
    );

    prs_back #(
        .MAX_NUMBER (MAX_NUMBER)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job       (job),
        .o_rsp       (o_rsp)
    );

endmodule
